// ===== rtl/tick_timebase_with_task_timers_macros.svh =====
// Assertion macros for the tick timebase checker.
// No dependencies; included by the checker file only.
`ifndef TICK_TIMEBASE_WITH_TASK_TIMERS_MACROS_SVH
`define TICK_TIMEBASE_WITH_TASK_TIMERS_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define TBT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tbt checker: same-cycle property failed");

// Next-cycle implication, disabled while in reset.
`define TBT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tbt checker: next-cycle property failed");

`endif

// ===== rtl/tbt_pkg.sv =====
// Shared types and constants for the tick timebase with task timers.
// No dependencies.
package tbt_pkg;

  localparam int NUM_TASKS = 8;
  localparam int TASK_W    = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int CNT_W     = $clog2(NUM_TASKS + 1);
  localparam int MASK_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PERIOD  = 2'd1;

  localparam logic [15:0] SHORT_PERIOD_RST = 16'd100;
  localparam logic [15:0] LONG_PERIOD_RST  = 16'd2000;

  typedef enum logic [2:0] {
    FN_TICK       = 3'd0,
    FN_LOAD_TICKS = 3'd1,
    FN_LOAD_MS    = 3'd2,
    FN_LOAD_TASK  = 3'd3,
    FN_QUERY      = 3'd4
  } tbt_func_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DELAY,
    ST_TICK,
    ST_SHORT,
    ST_LONG,
    ST_MUL,
    ST_SAT,
    ST_LOAD,
    ST_QUERY,
    ST_WALK
  } tbt_state_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] value;
    logic [2:0]  task_index;
    logic        clear_ms_flag;
    logic        clear_long_flag;
  } tbt_in_t;

  typedef struct packed {
    logic [31:0]       delay_left;
    logic              delay_done;
    logic              ms_flag;
    logic              long_flag;
    logic [31:0]       now_ticks;
    logic [31:0]       elapsed;
    logic [31:0]       task_left;
    logic [MASK_W-1:0] task_zero_mask;
  } tbt_res_t;

endpackage

// ===== rtl/tick_timebase_with_task_timers.sv =====
// A tick steps through the delay, tick, short and long prescaler states, a ms delay load through
// multiply and saturate, other loads and queries through one load or query state; unused codes go
// straight to the task timer walk, which ends all of them; the next start is taken during the result beat.
// One 32-bit adder serves delay, tick, prescaler, query and walk; the walk reads one entry a cycle from a RAM.
// Reset (async, active low) clears all counters, flags and task valid bits; periods go to 100/2000.
// The result beat lasts one cycle and cannot be stalled.
module tick_timebase_with_task_timers
  import tbt_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  tbt_in_t              in_i,
  output logic                 done_o,
  output tbt_res_t             res_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  tbt_state_e state_q, state_d;
  tbt_in_t    in_q, in_d;

  logic [15:0]        short_period_q, long_period_q;
  logic [31:0]        delay_q, delay_d, tick_q, tick_d;
  logic [15:0]        short_pre_q, short_pre_d, long_pre_q, long_pre_d;
  logic               ms_flag_q, ms_flag_d, long_flag_q, long_flag_d;
  logic               ms_fire_q, ms_fire_d;
  logic [31:0]        elapsed_q, elapsed_d, task_left_q, task_left_d;
  logic [MASK_W-1:0]  mask_q, mask_d;
  logic [47:0]        prod_q, prod_d;
  logic [CNT_W-1:0]   walk_cnt_q, walk_cnt_d;
  logic               rd_vld_q, rd_vld_d, rd_ok_q, rd_ok_d;
  logic [TASK_W-1:0]  rd_idx_q, rd_idx_d;
  logic [NUM_TASKS-1:0] valid_q, valid_d;
  logic               done_q, done_d;

  logic [31:0]       task_mem [NUM_TASKS];
  logic [31:0]       rdata_q;
  logic              mem_we;
  logic [TASK_W-1:0] mem_waddr;
  logic [31:0]       mem_wdata;

  logic [31:0] add_a, add_b, add_sum;
  logic        add_c;
  logic        fire_short, fire_long;
  logic [31:0] cur_val;
  logic        dec_en, idx_ok, accept, walk_last;

  assign accept      = start && !busy;
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign idx_ok      = (32'(in_q.task_index) < 32'(NUM_TASKS));
  assign cur_val     = rd_ok_q ? rdata_q : 32'd0;
  assign dec_en      = ms_fire_q && (cur_val != 32'd0);
  assign walk_last   = (state_q == ST_WALK) && rd_vld_q && (walk_cnt_q == CNT_W'(NUM_TASKS));

  // shared adder
  always_comb begin
    add_a = 32'd0;
    add_b = 32'd0;
    add_c = 1'b0;
    unique case (state_q)
      ST_DELAY: begin
        add_a = delay_q;
        add_b = (delay_q != 32'd0) ? 32'hFFFF_FFFF : 32'd0;
      end
      ST_TICK: begin
        add_a = tick_q;
        add_b = 32'd1;
      end
      ST_SHORT: begin
        add_a = {16'd0, short_pre_q};
        add_b = 32'd1;
      end
      ST_LONG: begin
        add_a = {16'd0, long_pre_q};
        add_b = 32'd1;
      end
      ST_QUERY: begin
        add_a = tick_q;
        add_b = ~in_q.value;
        add_c = (tick_q >= in_q.value);
      end
      ST_WALK: begin
        add_a = cur_val;
        add_b = dec_en ? 32'hFFFF_FFFF : 32'd0;
      end
      default: ;
    endcase
  end

  assign add_sum    = add_a + add_b + {31'd0, add_c};
  assign fire_short = (add_sum[16:0] >= {1'b0, short_period_q});
  assign fire_long  = (add_sum[16:0] >= {1'b0, long_period_q});

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_i.func) inside
            FN_TICK:                     state_d = ST_DELAY;
            FN_LOAD_TICKS, FN_LOAD_TASK: state_d = ST_LOAD;
            FN_LOAD_MS:                  state_d = ST_MUL;
            FN_QUERY:                    state_d = ST_QUERY;
            default:                     state_d = ST_WALK;
          endcase
        end
      end
      ST_DELAY: state_d = ST_TICK;
      ST_TICK:  state_d = ST_SHORT;
      ST_SHORT: state_d = ST_LONG;
      ST_LONG:  state_d = ST_WALK;
      ST_MUL:   state_d = ST_SAT;
      ST_SAT:   state_d = ST_WALK;
      ST_LOAD:  state_d = ST_WALK;
      ST_QUERY: state_d = ST_WALK;
      ST_WALK: begin
        if (walk_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath updates
  always_comb begin
    in_d        = in_q;
    delay_d     = delay_q;
    tick_d      = tick_q;
    short_pre_d = short_pre_q;
    long_pre_d  = long_pre_q;
    ms_flag_d   = ms_flag_q;
    long_flag_d = long_flag_q;
    ms_fire_d   = ms_fire_q;
    elapsed_d   = elapsed_q;
    task_left_d = task_left_q;
    mask_d      = mask_q;
    prod_d      = prod_q;
    walk_cnt_d  = walk_cnt_q;
    rd_vld_d    = rd_vld_q;
    rd_ok_d     = rd_ok_q;
    rd_idx_d    = rd_idx_q;
    valid_d     = valid_q;
    done_d      = walk_last;
    mem_we      = 1'b0;
    mem_waddr   = rd_idx_q;
    mem_wdata   = add_sum;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          in_d        = in_i;
          ms_flag_d   = ms_flag_q & ~in_i.clear_ms_flag;
          long_flag_d = long_flag_q & ~in_i.clear_long_flag;
          ms_fire_d   = 1'b0;
          elapsed_d   = 32'd0;
          task_left_d = 32'd0;
          mask_d      = '0;
          walk_cnt_d  = '0;
          rd_vld_d    = 1'b0;
        end
      end
      ST_DELAY: delay_d = add_sum;
      ST_TICK:  tick_d = add_sum;
      ST_SHORT: begin
        short_pre_d = fire_short ? 16'd0 : add_sum[15:0];
        if (fire_short) begin
          ms_flag_d = 1'b1;
          ms_fire_d = 1'b1;
        end
      end
      ST_LONG: begin
        long_pre_d = fire_long ? 16'd0 : add_sum[15:0];
        if (fire_long) begin
          long_flag_d = 1'b1;
        end
      end
      ST_MUL: prod_d = in_q.value * {32'd0, short_period_q};
      ST_SAT: delay_d = (prod_q[47:32] != 16'd0) ? 32'hFFFF_FFFF : prod_q[31:0];
      ST_LOAD: begin
        if (in_q.func == FN_LOAD_TICKS) begin
          delay_d = in_q.value;
        end
        if ((in_q.func == FN_LOAD_TASK) && idx_ok) begin
          mem_we             = 1'b1;
          mem_waddr          = TASK_W'(in_q.task_index);
          mem_wdata          = in_q.value;
          valid_d[mem_waddr] = 1'b1;
        end
      end
      ST_QUERY: elapsed_d = add_sum;
      ST_WALK: begin
        if (walk_cnt_q != CNT_W'(NUM_TASKS)) begin
          walk_cnt_d = walk_cnt_q + CNT_W'(1);
          rd_vld_d   = 1'b1;
          rd_idx_d   = walk_cnt_q[TASK_W-1:0];
          rd_ok_d    = valid_q[walk_cnt_q[TASK_W-1:0]];
        end else begin
          rd_vld_d = 1'b0;
        end
        if (rd_vld_q) begin
          mem_we            = 1'b1;
          valid_d[rd_idx_q] = 1'b1;
          for (int j = 0; j < MASK_W; j++) begin
            if ((j < NUM_TASKS) && (rd_idx_q == TASK_W'(j))) begin
              mask_d[j] = (add_sum == 32'd0);
            end
          end
          if (idx_ok && (rd_idx_q == TASK_W'(in_q.task_index))) begin
            task_left_d = add_sum;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      delay_q     <= '0;
      tick_q      <= '0;
      short_pre_q <= '0;
      long_pre_q  <= '0;
      ms_flag_q   <= 1'b0;
      long_flag_q <= 1'b0;
      ms_fire_q   <= 1'b0;
      walk_cnt_q  <= '0;
      rd_vld_q    <= 1'b0;
      valid_q     <= '0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      delay_q     <= delay_d;
      tick_q      <= tick_d;
      short_pre_q <= short_pre_d;
      long_pre_q  <= long_pre_d;
      ms_flag_q   <= ms_flag_d;
      long_flag_q <= long_flag_d;
      ms_fire_q   <= ms_fire_d;
      walk_cnt_q  <= walk_cnt_d;
      rd_vld_q    <= rd_vld_d;
      valid_q     <= valid_d;
      done_q      <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q        <= in_d;
    elapsed_q   <= elapsed_d;
    task_left_q <= task_left_d;
    mask_q      <= mask_d;
    prod_q      <= prod_d;
    rd_ok_q     <= rd_ok_d;
    rd_idx_q    <= rd_idx_d;
  end

  // task timer RAM
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      task_mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= task_mem[walk_cnt_q[TASK_W-1:0]];
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_period_q <= SHORT_PERIOD_RST;
      long_period_q  <= LONG_PERIOD_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_SHORT_PERIOD: short_period_q <= cfg_data_i;
        CFG_LONG_PERIOD:  long_period_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign done_o               = done_q;
  assign res_o.delay_left     = delay_q;
  assign res_o.delay_done     = (delay_q == 32'd0);
  assign res_o.ms_flag        = ms_flag_q;
  assign res_o.long_flag      = long_flag_q;
  assign res_o.now_ticks      = tick_q;
  assign res_o.elapsed        = elapsed_q;
  assign res_o.task_left      = task_left_q;
  assign res_o.task_zero_mask = mask_q;

endmodule

// ===== rtl/tbt_checker.sv =====
// Port-level checker for the tick timebase, bound to the top level.
// Depends on tbt_pkg and tick_timebase_with_task_timers_macros.svh.
`include "tick_timebase_with_task_timers_macros.svh"

module tbt_checker
  import tbt_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy,
  input logic     done_o,
  input tbt_res_t res_o
);

  `TBT_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)
  `TBT_ASSERT_IMP(a_done_idle, clk_i, rst_ni, done_o, !busy)
  `TBT_ASSERT_IMP(a_busy_fall_done, clk_i, rst_ni, $fell(busy), done_o)
  `TBT_ASSERT_IMP(a_delay_done, clk_i, rst_ni, done_o, res_o.delay_done != (|res_o.delay_left))

endmodule

bind tick_timebase_with_task_timers tbt_checker u_tbt_checker (.*);
